[hdl/zzac_pkg.sv]
// Package for the zigzag array counter: word types, controller states,
// command and status structs, and the modular add. No dependencies.
package zzac_pkg;

    localparam int DEF_MAX_RANGE = 2048;
    localparam int DEF_MAX_LEN   = 2048;

    localparam logic [29:0] PRIME = 30'd1000000007;

    typedef struct packed {
        logic [11:0] arr_len;
        logic [11:0] low_lim;
        logic [11:0] up_lim;
    } zzac_req_t;

    typedef struct packed {
        logic [29:0] count;
        logic        too_wide;
    } zzac_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_PASS,
        ST_DRAIN,
        ST_FINISH
    } zzac_state_t;

    typedef struct packed {
        logic load;
        logic pass_start;
        logic step;
        logic pass_end;
        logic out_load;
    } zzac_cmd_t;

    typedef struct packed {
        logic special;
        logic last_elem;
        logic last_pass;
    } zzac_sts_t;

    // Sum of two residues below the prime, reduced once.
    function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME})
            s = s - {1'b0, PRIME};
        return s[29:0];
    endfunction

endpackage

[hdl/zzac_ctrl.sv]
// Controller state machine of the zigzag array counter.
// Depends on zzac_pkg; drives commands to zzac_dp and owns the result valid.
module zzac_ctrl
    import zzac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  zzac_sts_t sts,
    output zzac_cmd_t cmd
);

    zzac_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = sts.special ? ST_FINISH : ST_START;
            end
            ST_START:
            begin
                cmd.pass_start = 1'b1;
                state_next     = ST_PASS;
            end
            ST_PASS:
            begin
                cmd.step = 1'b1;
                if (sts.last_elem)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // The last write of the pass lands here.
                cmd.pass_end = 1'b1;
                state_next   = sts.last_pass ? ST_FINISH : ST_START;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[hdl/zzac_dp.sv]
// Datapath of the zigzag array counter: count row memory, prefix-sum
// accumulators, pass and element counters, result register. Depends on zzac_pkg.
module zzac_dp
    import zzac_pkg::*;
#(
    parameter int MAX_RANGE = DEF_MAX_RANGE,
    parameter int MAX_LEN   = DEF_MAX_LEN
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  zzac_req_t req,
    input  zzac_cmd_t cmd,
    output zzac_sts_t sts,
    output zzac_rsp_t rsp
);

    localparam int AW = $clog2(MAX_RANGE);

    logic [29:0]   mem [MAX_RANGE];

    logic [11:0]   len_reg, lo_reg, hi_reg;
    logic [11:0]   passes_reg;
    logic [AW-1:0] idx_reg, wr_addr_reg, last_idx;
    logic [29:0]   rdata_reg, run_reg, tot_reg, elem;
    logic          rd_v_reg, dir_reg, first_reg;
    logic [29:0]   count_reg;
    logic          too_wide_reg;

    logic [11:0]   len_eff;
    logic [12:0]   width;
    logic          empty, wide;
    logic [29:0]   spec_count;

    // Length is clamped to the longest supported array.
    assign len_eff = (32'(req.arr_len) > MAX_LEN) ? 12'(MAX_LEN) : req.arr_len;

    assign empty    = (hi_reg < lo_reg);
    assign width    = {1'b0, hi_reg} - {1'b0, lo_reg} + 13'd1;
    assign wide     = !empty && (32'(width) > MAX_RANGE);
    assign last_idx = AW'(hi_reg - lo_reg);

    assign sts.special   = empty || wide || (len_reg == 12'd0) || (len_reg == 12'd1);
    assign sts.last_elem = dir_reg ? (idx_reg == '0) : (idx_reg == last_idx);
    assign sts.last_pass = (passes_reg == 12'd1);

    always_comb
    begin
        if (empty || wide || (len_reg == 12'd0))
            spec_count = '0;
        else
            spec_count = 30'(width);
    end

    // The first pass sees a row of ones, so the row needs no fill sweep.
    assign elem = first_reg ? 30'd1 : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
            mem[wr_addr_reg] <= run_reg;
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            dir_reg   <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.step;
            if (cmd.load)
            begin
                dir_reg   <= 1'b0;
                first_reg <= 1'b1;
            end
            else if (cmd.pass_end)
            begin
                dir_reg   <= !dir_reg;
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg    <= req.arr_len;
            lo_reg     <= req.low_lim;
            hi_reg     <= req.up_lim;
            passes_reg <= len_eff - 12'd1;
        end
        else if (cmd.pass_end)
        begin
            passes_reg <= passes_reg - 12'd1;
        end

        if (cmd.pass_start)
            idx_reg <= dir_reg ? last_idx : '0;
        else if (cmd.step)
            idx_reg <= dir_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));

        if (cmd.step)
            wr_addr_reg <= idx_reg;

        // Each written value is an exclusive running sum; the row total
        // of the final pass is gathered as the values are written.
        if (cmd.pass_start)
        begin
            run_reg <= '0;
            tot_reg <= '0;
        end
        else if (rd_v_reg)
        begin
            run_reg <= add_mod(run_reg, elem);
            tot_reg <= add_mod(tot_reg, run_reg);
        end

        if (cmd.out_load)
        begin
            count_reg    <= sts.special ? spec_count : add_mod(tot_reg, tot_reg);
            too_wide_reg <= wide;
        end
    end

    assign rsp.count    = count_reg;
    assign rsp.too_wide = too_wide_reg;

endmodule

[hdl/zigzag_array_counter_unit.sv]
// Zigzag array counter: each request word (arr_len, low_lim, up_lim) yields one
// response word with the number of strictly alternating arrays modulo 1000000007.
// Built from zzac_ctrl and zzac_dp; types come from zzac_pkg.
//
// A request of length L over a range of width W takes one sweep over the count row
// for every position after the first, one element per cycle through the single
// memory read and write port, with the states ST_DRAIN and ST_START to turn the
// sweep around. Empty ranges, ranges wider than MAX_RANGE, and lengths zero and
// one skip the sweeps and go from ST_SETUP to ST_FINISH. Lengths above MAX_LEN are
// clamped. The block works on one request at a time and takes a new request as
// soon as the previous result sits in the output register.
module zigzag_array_counter_unit
    import zzac_pkg::*;
#(
    parameter int MAX_RANGE = DEF_MAX_RANGE,
    parameter int MAX_LEN   = DEF_MAX_LEN
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  zzac_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output zzac_rsp_t rsp
);

    zzac_cmd_t cmd;
    zzac_sts_t sts;

    zzac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    zzac_dp #(
        .MAX_RANGE (MAX_RANGE),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

[hdl/zzac_chk.sv]
// Port-level checker for the zigzag array counter, bound to the top level.
// Depends on zzac_pkg.
module zzac_chk
    import zzac_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input zzac_req_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input zzac_rsp_t rsp
);

    a_count_residue: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count < PRIME))
        else $error("count word is not a residue of the prime");

    a_wide_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.too_wide) |-> (rsp.count == '0))
        else $error("too_wide word carries a nonzero count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while the previous one is still in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response word changed or dropped");

endmodule

bind zigzag_array_counter_unit zzac_chk u_zzac_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/tb_zigzag_array_counter_unit.sv]
// Testbench for zigzag_array_counter_unit: drives request words, predicts every
// response word with its own prefix-sum model, and checks them in order.
// Depends on zzac_pkg and the zigzag_array_counter_unit RTL.
module tb_zigzag_array_counter_unit
    import zzac_pkg::*;
();

    class zigzag_scoreboard;
        zzac_rsp_t   pending_counts[$];
        int          errors;
        int unsigned row [DEF_MAX_RANGE];

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction

        function int unsigned sum_mod(int unsigned a, int unsigned b);
            int unsigned s;
            s = a + b;
            if (s >= int'(PRIME))
                s = s - int'(PRIME);
            return s;
        endfunction

        function zzac_rsp_t count_zigzag(zzac_req_t r);
            zzac_rsp_t   res;
            int unsigned width;
            int unsigned len;
            int unsigned acc;
            int unsigned v;
            int unsigned tot;
            res = '0;
            if (r.up_lim < r.low_lim)
                return res;
            width = int'(r.up_lim) - int'(r.low_lim) + 1;
            if (width > DEF_MAX_RANGE) begin
                res.too_wide = 1'b1;
                return res;
            end
            len = r.arr_len;
            if (len == 0)
                return res;
            if (len > DEF_MAX_LEN)
                len = DEF_MAX_LEN;
            if (len == 1) begin
                res.count = 30'(width);
                return res;
            end
            for (int i = 0; i < width; i++)
                row[i] = 1;
            // Even positions sweep upward, odd positions sweep downward.
            for (int p = 2; p <= len; p++) begin
                acc = 0;
                if ((p % 2) == 0) begin
                    for (int i = 0; i < width; i++) begin
                        v = row[i];
                        row[i] = acc;
                        acc = sum_mod(acc, v);
                    end
                end
                else begin
                    for (int i = int'(width) - 1; i >= 0; i--) begin
                        v = row[i];
                        row[i] = acc;
                        acc = sum_mod(acc, v);
                    end
                end
            end
            tot = 0;
            for (int i = 0; i < width; i++)
                tot = sum_mod(tot, row[i]);
            tot = sum_mod(tot, tot);
            res.count = 30'(tot);
            return res;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        function void note_request(zzac_req_t r);
            pending_counts.push_back(count_zigzag(r));
        endfunction

        task check_response(zzac_rsp_t got);
            zzac_rsp_t want;
            if (pending_counts.size() == 0) begin
                report_mismatch("unexpected response word", got, -1);
                return;
            end
            want = pending_counts.pop_front();
            if (got.count != want.count)
                report_mismatch("count", got.count, want.count);
            if (got.too_wide != want.too_wide)
                report_mismatch("too_wide", got.too_wide, want.too_wide);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    zzac_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    zzac_rsp_t rsp;

    zigzag_scoreboard sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    int stall_asks;
    int stall_seen;
    int hold_left;

    zigzag_array_counter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // without touching req_valid, so a following word can keep it high.
    task send_request(zzac_req_t r);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        sb.note_request(r);
        @(negedge clk);
    endtask

    task send_fields(int len, int lo, int hi);
        zzac_req_t r;
        r.arr_len = 12'(len);
        r.low_lim = 12'(lo);
        r.up_lim  = 12'(hi);
        send_request(r);
    endtask

    task wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly small ranges and lengths; a few long lengths, or empty or wide ranges.
    function automatic zzac_req_t random_request();
        zzac_req_t r;
        int kind;
        int w;
        int lo;
        kind = $urandom_range(0, 99);
        r.arr_len = 12'($urandom_range(0, 20));
        if (kind < 70) begin
            w = $urandom_range(1, 16);
        end
        else if (kind < 80) begin
            lo = $urandom_range(1, 4095);
            r.arr_len = 12'($urandom_range(0, 4095));
            r.low_lim = 12'(lo);
            r.up_lim  = 12'($urandom_range(0, lo - 1));
            return r;
        end
        else if (kind < 88) begin
            lo = $urandom_range(0, 2047);
            r.arr_len = 12'($urandom_range(0, 4095));
            r.low_lim = 12'(lo);
            r.up_lim  = 12'($urandom_range(lo + 2048, 4095));
            return r;
        end
        else if (kind < 95) begin
            w = $urandom_range(1, 3);
            r.arr_len = 12'($urandom_range(0, 4095));
        end
        else begin
            w = $urandom_range(1, DEF_MAX_RANGE);
            r.arr_len = 12'($urandom_range(2, 3));
        end
        lo = $urandom_range(0, 4096 - w);
        r.low_lim = 12'(lo);
        r.up_lim  = 12'(lo + w - 1);
        return r;
    endfunction

    task send_random(int n);
        for (int k = 0; k < n; k++)
            send_request(random_request());
    endtask

    // The receiver runs on its own; a long hold-off is asked for by bumping
    // stall_asks and is then counted down here.
    initial
    begin
        rsp_ready  = 1'b0;
        stall_seen = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (stall_seen != stall_asks) begin
                stall_seen = stall_asks;
                hold_left  = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else begin
                rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    initial
    begin
        zzac_req_t r;
        sb           = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        snd_idle_pct = 19;
        rcv_idle_pct = 77;
        stall_asks   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: trivial lengths, empty and oversized ranges,
        // clamped lengths and the full-width row.
        send_fields(0, 0, 0);
        send_fields(1, 0, 0);
        send_fields(1, 0, 2047);
        send_fields(1, 2048, 4095);
        send_fields(1, 4095, 4095);
        send_fields(2, 0, 2047);
        send_fields(2, 2048, 4095);
        send_fields(3, 5, 5);
        send_fields(2, 3, 4);
        send_fields(3, 1, 3);
        send_fields(5, 10, 9);
        send_fields(4095, 4095, 0);
        send_fields(4095, 0, 4095);
        send_fields(1, 0, 2048);
        send_fields(0, 1000, 3100);
        send_fields(2048, 4094, 4095);
        send_fields(4095, 4093, 4095);
        send_fields(2049, 0, 1);
        send_fields(12, 100, 130);
        send_fields(20, 7, 22);
        send_random(24);
        wait_drained();

        // Stall the receiver long enough that the block backs up on its input.
        snd_idle_pct = 0;
        stall_asks++;
        for (int k = 0; k < 8; k++) begin
            r.arr_len = 12'($urandom_range(0, 4));
            r.low_lim = 12'($urandom_range(0, 4092));
            r.up_lim  = r.low_lim + 12'($urandom_range(0, 3));
            send_request(r);
        end
        wait_drained();

        snd_idle_pct = 77;
        rcv_idle_pct = 19;
        send_random(24);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random(24);
        wait_drained();

        repeat (64) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
